### sv/fcgi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcgi_pkg;

   // Record parser phase.
   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_CONTENT = 2'd1,
      PH_PADDING = 2'd2
   } phase_type;

   // Byte positions inside the 8-byte record header.
   localparam int HDR_IDX_W = 3;
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_TYPE    = 3'd1;
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_REQ_HI  = 3'd2;
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_REQ_LO  = 3'd3;
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_LEN_HI  = 3'd4;
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_LEN_LO  = 3'd5;
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_PAD     = 3'd6;
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_LAST    = 3'd7;

   // Queue between the parser and the output stage.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // One result beat.
   typedef struct packed {
      logic        has_data;
      logic [7:0]  payload_byte;
      logic [7:0]  record_type;
      logic [15:0] request_id;
      logic [15:0] content_length;
      logic        record_end;
   } rsp_item_type;

   // Parser to queue write side.
   typedef struct packed {
      logic         push;
      rsp_item_type item;
   } push_type;

endpackage

`default_nettype wire

### sv/fcgi_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fcgi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

### sv/fcgi_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fcgi_rsp_if;
   logic        valid;
   logic        ready;
   logic        has_data;
   logic [7:0]  payload_byte;
   logic [7:0]  record_type;
   logic [15:0] request_id;
   logic [15:0] content_length;
   logic        record_end;

   modport source (
      output valid, output has_data, output payload_byte, output record_type,
      output request_id, output content_length, output record_end, input ready
   );
   modport sink (
      input valid, input has_data, input payload_byte, input record_type,
      input request_id, input content_length, input record_end, output ready
   );
endinterface

`default_nettype wire

### sv/fcgi_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fcgi_front (
   input  wire logic              clock,
   input  wire logic              reset,
   fcgi_req_if.sink               req_ch,
   input  wire logic              queue_full,
   output fcgi_pkg::push_type     wr
);
   import fcgi_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [7:0]  hdr_type_ff, hdr_type_in;
   logic [15:0] hdr_request_ff, hdr_request_in;
   logic [15:0] hdr_content_len_ff, hdr_content_len_in;
   logic [7:0]  hdr_padding_len_ff, hdr_padding_len_in;

   logic        accept;
   logic [15:0] count_next;
   logic [HDR_IDX_W-1:0] hdr_idx;
   logic        content_done;
   logic        padding_done;

   // A byte is taken whenever the queue has a free slot.
   assign req_ch.ready = ~queue_full;
   assign accept       = req_ch.valid & ~queue_full;

   assign count_next   = byte_count_ff + 16'd1;
   assign hdr_idx      = byte_count_ff[HDR_IDX_W-1:0];
   assign content_done = (count_next >= hdr_content_len_ff);
   assign padding_done = (count_next >= {8'd0, hdr_padding_len_ff});

   // Next state: phase, byte counter and header fields.
   always_comb begin
      phase_in           = phase_ff;
      byte_count_in      = byte_count_ff;
      hdr_type_in        = hdr_type_ff;
      hdr_request_in     = hdr_request_ff;
      hdr_content_len_in = hdr_content_len_ff;
      hdr_padding_len_in = hdr_padding_len_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_CONTENT: begin
               if (content_done) begin
                  byte_count_in = 16'd0;
                  phase_in = (hdr_padding_len_ff == 8'd0) ? PH_HEADER : PH_PADDING;
               end else begin
                  byte_count_in = count_next;
               end
            end
            PH_PADDING: begin
               if (padding_done) begin
                  byte_count_in = 16'd0;
                  phase_in      = PH_HEADER;
               end else begin
                  byte_count_in = count_next;
               end
            end
            PH_HEADER: begin
               unique case (hdr_idx)
                  HDR_IDX_TYPE:   hdr_type_in               = req_ch.data_byte;
                  HDR_IDX_REQ_HI: hdr_request_in[15:8]      = req_ch.data_byte;
                  HDR_IDX_REQ_LO: hdr_request_in[7:0]       = req_ch.data_byte;
                  HDR_IDX_LEN_HI: hdr_content_len_in[15:8]  = req_ch.data_byte;
                  HDR_IDX_LEN_LO: hdr_content_len_in[7:0]   = req_ch.data_byte;
                  HDR_IDX_PAD:    hdr_padding_len_in        = req_ch.data_byte;
                  default: ;
               endcase
               if (hdr_idx == HDR_IDX_LAST) begin
                  byte_count_in = 16'd0;
                  if (hdr_content_len_ff != 16'd0) begin
                     phase_in = PH_CONTENT;
                  end else if (hdr_padding_len_ff != 8'd0) begin
                     phase_in = PH_PADDING;
                  end else begin
                     phase_in = PH_HEADER;
                  end
               end else begin
                  byte_count_in = count_next;
               end
            end
            default: begin
               // Unused phase code restarts a header at its first byte.
               phase_in      = PH_HEADER;
               byte_count_in = 16'd1;
            end
         endcase
      end
   end

   // Outputs: which accepted bytes give a result beat.
   always_comb begin
      wr.push                = 1'b0;
      wr.item.has_data       = 1'b0;
      wr.item.payload_byte   = 8'd0;
      wr.item.record_type    = hdr_type_ff;
      wr.item.request_id     = hdr_request_ff;
      wr.item.content_length = hdr_content_len_ff;
      wr.item.record_end     = 1'b0;
      unique case (phase_ff)
         PH_CONTENT: begin
            wr.push              = accept;
            wr.item.has_data     = 1'b1;
            wr.item.payload_byte = req_ch.data_byte;
            wr.item.record_end   = content_done & (hdr_padding_len_ff == 8'd0);
         end
         PH_PADDING: begin
            wr.push            = accept & padding_done;
            wr.item.record_end = 1'b1;
         end
         PH_HEADER: begin
            // Empty record ends on its last header byte.
            wr.push = accept & (hdr_idx == HDR_IDX_LAST) &
                      (hdr_content_len_ff == 16'd0) & (hdr_padding_len_ff == 8'd0);
            wr.item.record_end = 1'b1;
         end
         default: ;
      endcase
   end

   // Parser control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         byte_count_ff <= 16'd0;
      end else begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
      end
   end

   // Header field registers; cleared at reset so early results read zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_type_ff        <= 8'd0;
         hdr_request_ff     <= 16'd0;
         hdr_content_len_ff <= 16'd0;
         hdr_padding_len_ff <= 8'd0;
      end else begin
         hdr_type_ff        <= hdr_type_in;
         hdr_request_ff     <= hdr_request_in;
         hdr_content_len_ff <= hdr_content_len_in;
         hdr_padding_len_ff <= hdr_padding_len_in;
      end
   end

endmodule

`default_nettype wire

### sv/fcgi_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fcgi_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fcgi_pkg::push_type    wr,
   output logic                       full,
   output logic                       rd_valid,
   output fcgi_pkg::rsp_item_type     rd_item,
   input  wire logic                  pop
);
   import fcgi_pkg::*;

   rsp_item_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = entry_ff[rd_ptr_ff];
   assign do_push  = wr.push & ~full;
   assign do_pop   = pop & rd_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr.item;
      end
   end

endmodule

`default_nettype wire

### sv/fcgi_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fcgi_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rd_valid,
   input  wire fcgi_pkg::rsp_item_type rd_item,
   output logic                       pop,
   fcgi_rsp_if.source                 rsp_ch
);
   import fcgi_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;
   logic         load;

   // Refill the output register when it is empty or being drained.
   assign load     = rd_valid & (~valid_ff | rsp_ch.ready);
   assign pop      = load;
   assign valid_in = load | (valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= rd_item;
      end
   end

   // Drive the result channel from the output register.
   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.has_data       = item_ff.has_data;
   assign rsp_ch.payload_byte   = item_ff.payload_byte;
   assign rsp_ch.record_type    = item_ff.record_type;
   assign rsp_ch.request_id     = item_ff.request_id;
   assign rsp_ch.content_length = item_ff.content_length;
   assign rsp_ch.record_end     = item_ff.record_end;

endmodule

`default_nettype wire

### sv/fastcgi_record_deframer_unit.sv
// FastCGI record deframer.
// The req_ch channel carries one raw stream byte per beat; the rsp_ch channel
// carries one result beat per content byte, with the record's type, request id
// and content length, plus an end-only beat where padding or an empty record
// finishes. Header and padding bytes otherwise produce no beat.
// Throughput is one byte per cycle: the parser updates its counters and header
// registers as each byte is accepted, so req_ch.ready stays high as long as the
// two-entry queue between the parser and the output register has room.
// A result beat is written into the queue as the byte that caused it is accepted,
// then moves into the output register that presents it on rsp_ch.
// When the receiver stalls, the output register holds its beat, the queue fills,
// and req_ch.ready drops once both queue entries are taken.
// Reset is synchronous and returns the parser to the start of a header with all
// header fields zero, and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module fastcgi_record_deframer_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   fcgi_req_if.sink    req_ch,
   fcgi_rsp_if.source  rsp_ch
);
   import fcgi_pkg::*;

   push_type     wr;
   logic         queue_full;
   logic         rd_valid;
   rsp_item_type rd_item;
   logic         pop;

   // Parser: classifies each byte and decodes headers.
   fcgi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .wr         (wr)
   );

   // Decoupling queue.
   fcgi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .full     (queue_full),
      .rd_valid (rd_valid),
      .rd_item  (rd_item),
      .pop      (pop)
   );

   // Output stage.
   fcgi_back u_back (
      .clock    (clock),
      .reset    (reset),
      .rd_valid (rd_valid),
      .rd_item  (rd_item),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

### bench/fastcgi_record_deframer_unit_tb.sv
`timescale 1ns / 1ps

module fastcgi_record_deframer_unit_tb;
   import fcgi_pkg::*;

   localparam int RANDOM_BYTES   = 1520;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DIRECTED_ROWS  = 26;

   // How a directed row is checked: against the predictor, as a byte that
   // must cause no beat, or against the beat typed into the row.
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_QUIET,
      ROW_BEAT
   } row_kind_type;

   typedef struct packed {
      logic [7:0]   data;
      row_kind_type kind;
      rsp_item_type beat;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   fcgi_req_if req_ch ();
   fcgi_rsp_if rsp_ch ();

   fastcgi_record_deframer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #10 clock = ~clock;

   // Parser state of the predictor.
   phase_type   prs_phase;
   logic [15:0] prs_count;
   logic [7:0]  prs_type;
   logic [15:0] prs_request;
   logic [15:0] prs_length;
   logic [7:0]  prs_padding;

   rsp_item_type pending_beats[$];
   int mismatch_count = 0;
   int bytes_sent = 0;
   int send_idle_pct = 0;
   int take_stall_pct = 0;
   int quiet_cycles = 0;

   // Directed stream: an empty record with all-ones type and request id, a one-byte
   // record without padding, and a record with no content but one padding byte.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'hFF, ROW_QUIET, '0},
      '{8'hFF, ROW_QUIET, '0},
      '{8'hFF, ROW_QUIET, '0},
      '{8'hFF, ROW_QUIET, '0},
      '{8'h00, ROW_QUIET, '0},
      '{8'h00, ROW_QUIET, '0},
      '{8'h00, ROW_QUIET, '0},
      '{8'hFF, ROW_BEAT, '{1'b0, 8'h00, 8'hFF, 16'hFFFF, 16'h0000, 1'b1}},
      '{8'h01, ROW_QUIET, '0},
      '{8'h00, ROW_QUIET, '0},
      '{8'h00, ROW_QUIET, '0},
      '{8'h00, ROW_QUIET, '0},
      '{8'h00, ROW_QUIET, '0},
      '{8'h01, ROW_QUIET, '0},
      '{8'h00, ROW_QUIET, '0},
      '{8'h00, ROW_QUIET, '0},
      '{8'hFF, ROW_BEAT, '{1'b1, 8'hFF, 8'h00, 16'h0000, 16'h0001, 1'b1}},
      '{8'h01, ROW_PREDICT, '0},
      '{8'h05, ROW_PREDICT, '0},
      '{8'h12, ROW_PREDICT, '0},
      '{8'h34, ROW_PREDICT, '0},
      '{8'h00, ROW_PREDICT, '0},
      '{8'h00, ROW_PREDICT, '0},
      '{8'h01, ROW_PREDICT, '0},
      '{8'h00, ROW_PREDICT, '0},
      '{8'hA5, ROW_BEAT, '{1'b0, 8'h00, 8'h05, 16'h1234, 16'h0000, 1'b1}}
   };

   // Append an expected beat at the tail of the scoreboard queue.
   function automatic void queue_beat(input rsp_item_type b);
      pending_beats.insert(pending_beats.size(), b);
   endfunction

   // Advance the predicted parser by one stream byte. Returns 1 when the byte
   // causes a result beat, which is then placed in beat.
   function automatic bit deframe_byte(input logic [7:0] b, output rsp_item_type beat);
      logic [15:0] next_count;
      bit          produced;
      logic        has;
      logic [7:0]  payload;
      logic        last;
      produced   = 1'b0;
      has        = 1'b0;
      payload    = 8'h00;
      last       = 1'b0;
      next_count = prs_count + 16'd1;
      if (prs_phase == PH_CONTENT) begin
         produced = 1'b1;
         has      = 1'b1;
         payload  = b;
         if (next_count >= prs_length) begin
            prs_count = '0;
            if (prs_padding == 8'h00) begin
               prs_phase = PH_HEADER;
               last      = 1'b1;
            end else begin
               prs_phase = PH_PADDING;
            end
         end else begin
            prs_count = next_count;
         end
      end else if (prs_phase == PH_PADDING) begin
         if (next_count >= {8'h00, prs_padding}) begin
            prs_phase = PH_HEADER;
            prs_count = '0;
            produced  = 1'b1;
            last      = 1'b1;
         end else begin
            prs_count = next_count;
         end
      end else begin
         // Any other phase code restarts a header at its first byte.
         if (prs_phase != PH_HEADER) begin
            prs_phase = PH_HEADER;
            prs_count = '0;
         end
         case (prs_count)
            16'(HDR_IDX_TYPE):   prs_type = b;
            16'(HDR_IDX_REQ_HI): prs_request[15:8] = b;
            16'(HDR_IDX_REQ_LO): prs_request[7:0] = b;
            16'(HDR_IDX_LEN_HI): prs_length[15:8] = b;
            16'(HDR_IDX_LEN_LO): prs_length[7:0] = b;
            16'(HDR_IDX_PAD):    prs_padding = b;
            default: ;
         endcase
         if (prs_count == 16'(HDR_IDX_LAST)) begin
            prs_count = '0;
            if (prs_length != 16'h0000) begin
               prs_phase = PH_CONTENT;
            end else if (prs_padding != 8'h00) begin
               prs_phase = PH_PADDING;
            end else begin
               produced = 1'b1;
               last     = 1'b1;
            end
         end else begin
            prs_count = prs_count + 16'd1;
         end
      end
      beat.has_data       = has;
      beat.payload_byte   = payload;
      beat.record_type    = prs_type;
      beat.request_id     = prs_request;
      beat.content_length = prs_length;
      beat.record_end     = last;
      return produced;
   endfunction

   // Offer one byte, with random idle cycles ahead of it, and return at the
   // rising edge where the beat is taken, with the predicted result.
   task automatic send_byte(input logic [7:0] b, output bit produced,
                            output rsp_item_type beat);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
      produced = deframe_byte(b, beat);
   endtask

   task automatic stream_byte(input logic [7:0] b);
      bit           produced;
      rsp_item_type beat;
      send_byte(b, produced, beat);
      if (produced) queue_beat(beat);
   endtask

   // One well-formed record; version, reserved, content and padding are random.
   task automatic send_record(input logic [7:0] rec_type, input logic [15:0] req_id,
                              input logic [15:0] len, input logic [7:0] pad);
      logic [7:0] hdr [8];
      hdr[0] = 8'($urandom_range(255));
      hdr[1] = rec_type;
      hdr[2] = req_id[15:8];
      hdr[3] = req_id[7:0];
      hdr[4] = len[15:8];
      hdr[5] = len[7:0];
      hdr[6] = pad;
      hdr[7] = 8'($urandom_range(255));
      foreach (hdr[i]) stream_byte(hdr[i]);
      for (int i = 0; i < len; i++) stream_byte(8'($urandom_range(255)));
      for (int i = 0; i < pad; i++) stream_byte(8'($urandom_range(255)));
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Receiver ready, redrawn every cycle.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= take_stall_pct);
   end

   // Compare every result beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_beats.size() == 0) begin
            $error("result beat with no expectation waiting");
            mismatch_count++;
         end else begin
            want = pending_beats.pop_front();
            check_field("has_data", 16'(want.has_data), 16'(rsp_ch.has_data));
            check_field("payload_byte", 16'(want.payload_byte), 16'(rsp_ch.payload_byte));
            check_field("record_type", 16'(want.record_type), 16'(rsp_ch.record_type));
            check_field("request_id", want.request_id, rsp_ch.request_id);
            check_field("content_length", want.content_length, rsp_ch.content_length);
            check_field("record_end", 16'(want.record_end), 16'(rsp_ch.record_end));
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bit           produced;
      rsp_item_type beat;
      int           record_count;
      int           random_start;
      int           mode;
      logic [15:0]  len;
      logic [7:0]   pad;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'h00;
      prs_phase        = PH_HEADER;
      prs_count        = '0;
      prs_type         = '0;
      prs_request      = '0;
      prs_length       = '0;
      prs_padding      = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows, with no idling on either side.
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].data, produced, beat);
         case (directed_rows[i].kind)
            ROW_BEAT:    queue_beat(directed_rows[i].beat);
            ROW_PREDICT: if (produced) queue_beat(beat);
            default: ;
         endcase
      end

      // Random records, walking through the idling modes in turn.
      record_count = 0;
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         mode = ((bytes_sent - random_start) * 4) / RANDOM_BYTES;
         case (mode)
            0:       begin send_idle_pct = 0;  take_stall_pct = 0;  end
            1:       begin send_idle_pct = 68; take_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  take_stall_pct = 68; end
            default: begin send_idle_pct = 15; take_stall_pct = 15; end
         endcase
         len = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(12, 1));
         pad = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(7, 1));
         // A few records reach past 255 content bytes or the widest padding.
         if (record_count == 10 || record_count == 35) begin
            len = 16'($urandom_range(320, 256));
         end
         if (record_count == 25) pad = 8'hFF;
         send_record(8'($urandom_range(255)), 16'($urandom_range(65535)), len, pad);
         record_count++;
      end

      @(negedge clock);
      req_ch.valid   <= 1'b0;
      send_idle_pct  = 0;
      take_stall_pct = 0;

      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
